// ----- sv/fdt_pkg.sv -----
// Shared types and codes of the foreign device table.
// Used by the table RAM, the sequencer, the top level and the testbench.
package fdt_pkg;

    typedef enum logic [1:0] {
        CMD_REGISTER = 2'd0,
        CMD_TICK     = 2'd1,
        CMD_DELETE   = 2'd2,
        CMD_READ     = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FULL        = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND   = 2'd3;

    localparam logic CFG_FD_SUPPORT = 1'b0;
    localparam logic CFG_TTL_GRACE  = 1'b1;

    localparam logic [7:0] TTL_GRACE_RESET = 8'd30;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] ttl;
        logic [16:0] remaining;
    } t_entry;

    typedef struct packed {
        logic       we;
        t_entry     wdata;
    } t_ram_wr;

    typedef struct packed {
        logic       fd_support;
        logic [7:0] ttl_grace;
    } t_cfg;

endpackage

// ----- sv/fdt_req_if.sv -----
// Request channel of the foreign device table.
// Depends on nothing.
interface fdt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] ip_address;
    logic [15:0] udp_port;
    logic [15:0] time_to_live;
    logic [3:0]  entry_index;

    modport source (output valid, output cmd, output ip_address, output udp_port,
                    output time_to_live, output entry_index, input ready);
    modport sink (input valid, input cmd, input ip_address, input udp_port,
                  input time_to_live, input entry_index, output ready);
endinterface

// ----- sv/fdt_rsp_if.sv -----
// Result channel of the foreign device table.
// Depends on nothing.
interface fdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic        entry_valid;
    logic [31:0] entry_ip;
    logic [15:0] entry_port;
    logic [15:0] entry_ttl;
    logic [16:0] entry_remaining;

    modport source (output valid, output status, output entry_count, output entry_valid,
                    output entry_ip, output entry_port, output entry_ttl,
                    output entry_remaining, input ready);
    modport sink (input valid, input status, input entry_count, input entry_valid,
                  input entry_ip, input entry_port, input entry_ttl,
                  input entry_remaining, output ready);
endinterface

// ----- sv/fdt_ram.sv -----
// Entry storage: one write port, one registered read port.
// Depends on fdt_pkg.
module fdt_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  fdt_pkg::t_ram_wr i_wr,
    input  logic [AW-1:0]   i_waddr,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output fdt_pkg::t_entry o_rdata
);

    fdt_pkg::t_entry r_mem [DEPTH];
    fdt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/fdt_ctrl.sv -----
// Sequencer: walks the table one entry at a time through the RAM port,
// with one shared adder and one address/port comparator. Depends on fdt_pkg.
module fdt_ctrl #(
    parameter int MAX_ENTRIES = 16,
    parameter int AW          = 4,
    parameter int CW          = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fdt_req_if.sink          i_req,
    fdt_rsp_if.source        o_rsp,
    input  fdt_pkg::t_cfg    i_cfg,
    output fdt_pkg::t_ram_wr o_wr,
    output logic [AW-1:0]    o_waddr,
    output logic             o_re,
    output logic [AW-1:0]    o_raddr,
    input  fdt_pkg::t_entry  i_rdata
);

    localparam int IW = (CW > 4) ? CW : 4;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    fdt_pkg::t_cmd   r_cmd, n_cmd;
    logic [31:0]     r_ip, n_ip;
    logic [15:0]     r_port, n_port;
    logic [15:0]     r_ttl, n_ttl;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_wr_ptr, n_wr_ptr;
    logic            r_shift, n_shift;
    logic [CW-1:0]   r_count, n_count;
    logic [1:0]      r_status, n_status;
    logic            r_hit, n_hit;
    fdt_pkg::t_entry r_entry, n_entry;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_out_status, n_out_status;
    logic [4:0]      r_out_count, n_out_count;
    logic            r_out_hit, n_out_hit;
    fdt_pkg::t_entry r_out_entry, n_out_entry;

    logic [16:0]     add_a, add_b, add_sum;
    logic            match;
    logic            alive;
    logic [CW-1:0]   ptr_inc, ptr_dec;
    logic [IW-1:0]   idx_ext, cnt_ext;
    logic            accept;

    assign match   = (i_rdata.ip == r_ip) && (i_rdata.port == r_port);
    assign alive   = i_rdata.remaining > 17'd1;
    assign add_a   = (r_cmd == fdt_pkg::CMD_TICK) ? i_rdata.remaining : {1'b0, r_ttl};
    assign add_b   = (r_cmd == fdt_pkg::CMD_TICK) ? '1 : {9'd0, i_cfg.ttl_grace};
    assign add_sum = add_a + add_b;
    assign ptr_inc = r_ptr + CW'(1);
    assign ptr_dec = r_ptr - CW'(1);
    assign idx_ext = IW'(i_req.entry_index);
    assign cnt_ext = IW'(r_count);
    assign accept  = i_req.valid && i_req.ready;

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_ip         = r_ip;
        n_port       = r_port;
        n_ttl        = r_ttl;
        n_ptr        = r_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_shift      = r_shift;
        n_count      = r_count;
        n_status     = r_status;
        n_hit        = r_hit;
        n_entry      = r_entry;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_hit    = r_out_hit;
        n_out_entry  = r_out_entry;
        o_wr.we      = 1'b0;
        o_wr.wdata   = i_rdata;
        o_waddr      = r_ptr[AW-1:0];
        o_re         = 1'b0;
        o_raddr      = r_ptr[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = fdt_pkg::t_cmd'(i_req.cmd);
                    n_ip     = i_req.ip_address;
                    n_port   = i_req.udp_port;
                    n_ttl    = i_req.time_to_live;
                    n_ptr    = '0;
                    n_wr_ptr = '0;
                    n_shift  = 1'b0;
                    n_status = fdt_pkg::ST_OK;
                    n_hit    = 1'b0;
                    n_entry  = '0;
                    n_state  = S_SCAN;
                    case (fdt_pkg::t_cmd'(i_req.cmd))
                        fdt_pkg::CMD_REGISTER: begin
                            if (!i_cfg.fd_support) begin
                                n_status = fdt_pkg::ST_UNSUPPORTED;
                                n_state  = S_DONE;
                            end else if (r_count >= CW'(MAX_ENTRIES)) begin
                                n_status = fdt_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end
                        end
                        fdt_pkg::CMD_READ: begin
                            if (idx_ext < cnt_ext) begin
                                n_ptr = idx_ext[CW-1:0];
                            end else begin
                                n_status = fdt_pkg::ST_NOT_FOUND;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_ptr < r_count) begin
                    o_re    = 1'b1;
                    n_state = S_EVAL;
                end else begin
                    n_state = S_DONE;
                    case (r_cmd)
                        fdt_pkg::CMD_REGISTER: begin
                            o_wr.we    = 1'b1;
                            o_wr.wdata = '{ip: r_ip, port: r_port, ttl: r_ttl,
                                           remaining: {1'b0, r_ttl}};
                            n_count    = r_count + CW'(1);
                        end
                        fdt_pkg::CMD_TICK: begin
                            n_count = r_wr_ptr;
                        end
                        fdt_pkg::CMD_DELETE: begin
                            if (r_shift) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_status = fdt_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EVAL: begin
                n_ptr   = ptr_inc;
                n_state = S_SCAN;
                case (r_cmd)
                    fdt_pkg::CMD_REGISTER: begin
                        if (match) begin
                            o_wr.we    = 1'b1;
                            o_wr.wdata = '{ip: i_rdata.ip, port: i_rdata.port, ttl: r_ttl,
                                           remaining: add_sum};
                            n_state    = S_DONE;
                        end
                    end
                    fdt_pkg::CMD_TICK: begin
                        if (alive) begin
                            o_wr.we              = 1'b1;
                            o_wr.wdata.remaining = add_sum;
                            o_waddr              = r_wr_ptr[AW-1:0];
                            n_wr_ptr             = r_wr_ptr + CW'(1);
                        end
                    end
                    fdt_pkg::CMD_DELETE: begin
                        if (r_shift) begin
                            o_wr.we = 1'b1;
                            o_waddr = ptr_dec[AW-1:0];
                        end else if (match) begin
                            n_shift = 1'b1;
                        end
                    end
                    default: begin
                        n_hit   = 1'b1;
                        n_entry = i_rdata;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = 5'(r_count);
                    n_out_hit    = r_hit;
                    n_out_entry  = r_entry;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_ip         <= n_ip;
        r_port       <= n_port;
        r_ttl        <= n_ttl;
        r_ptr        <= n_ptr;
        r_wr_ptr     <= n_wr_ptr;
        r_shift      <= n_shift;
        r_status     <= n_status;
        r_hit        <= n_hit;
        r_entry      <= n_entry;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_hit    <= n_out_hit;
        r_out_entry  <= n_out_entry;
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.entry_count     = r_out_count;
    assign o_rsp.entry_valid     = r_out_hit;
    assign o_rsp.entry_ip        = r_out_entry.ip;
    assign o_rsp.entry_port      = r_out_entry.port;
    assign o_rsp.entry_ttl       = r_out_entry.ttl;
    assign o_rsp.entry_remaining = r_out_entry.remaining;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_wr_ptr <= r_ptr))
        else $error("compaction write pointer passed read pointer");

    a_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.we |-> (r_state == S_SCAN || r_state == S_EVAL))
        else $error("table write outside a walk");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("request taken while previous one in flight");

endmodule

// ----- sv/foreign_device_table_top.sv -----
// Top level of the foreign device table: configuration registers, table RAM
// and sequencer. Depends on fdt_pkg, fdt_req_if, fdt_rsp_if, fdt_ram, fdt_ctrl.
//
//   Channel  Dir  Handshake           Payload
//   i_req    in   valid/ready         cmd, ip_address, udp_port, time_to_live, entry_index
//   o_rsp    out  valid/ready         status, entry_count, entry_valid, entry_*
//   i_cfg_*  in   i_cfg_we, no wait   i_cfg_idx, i_cfg_wdata
//
// Register, tick and delete walk the table through the single RAM read port,
// passing S_SCAN then S_EVAL for each entry walked; read visits only its entry.
// A refused register or an out-of-range read goes from S_IDLE straight to S_DONE.
// Reset clears count, state, output valid and config; the RAM is written before read.
// A stalled result holds in the output register; the next request is taken meanwhile.
module foreign_device_table_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fdt_req_if.sink    i_req,
    fdt_rsp_if.source  o_rsp,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    fdt_pkg::t_cfg    r_cfg;
    fdt_pkg::t_ram_wr wr;
    logic [AW-1:0]    waddr;
    logic             re;
    logic [AW-1:0]    raddr;
    fdt_pkg::t_entry  rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fd_support <= 1'b0;
            r_cfg.ttl_grace  <= fdt_pkg::TTL_GRACE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fdt_pkg::CFG_FD_SUPPORT: r_cfg.fd_support <= i_cfg_wdata[0];
                fdt_pkg::CFG_TTL_GRACE:  r_cfg.ttl_grace  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    fdt_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_waddr (waddr),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    fdt_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (r_cfg),
        .o_wr    (wr),
        .o_waddr (waddr),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

endmodule

// ----- tb/foreign_device_table_top_tb.sv -----
// Testbench of foreign_device_table_top: directed and random register, tick,
// delete and read requests checked against a predictor of the device table.
// Depends on fdt_pkg, fdt_req_if, fdt_rsp_if and the foreign_device_table_top RTL.
module foreign_device_table_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH    = 16;
    localparam int POOL_SIZE      = 20;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ITEMS    = 116;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        fdt_pkg::t_cmd cmd;
        logic [31:0]   ip;
        logic [15:0]   port;
        logic [15:0]   ttl;
        logic [3:0]    idx;
    } t_fd_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  entry_count;
        logic        entry_valid;
        logic [31:0] entry_ip;
        logic [15:0] entry_port;
        logic [15:0] entry_ttl;
        logic [16:0] entry_remaining;
    } t_fd_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        req_valid = 1'b0;
    logic [1:0]  req_cmd = '0;
    logic [31:0] req_ip = '0;
    logic [15:0] req_port = '0;
    logic [15:0] req_ttl = '0;
    logic [3:0]  req_idx = '0;
    logic        rsp_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    fdt_req_if req_if ();
    fdt_rsp_if rsp_if ();

    assign req_if.valid        = req_valid;
    assign req_if.cmd          = req_cmd;
    assign req_if.ip_address   = req_ip;
    assign req_if.udp_port     = req_port;
    assign req_if.time_to_live = req_ttl;
    assign req_if.entry_index  = req_idx;
    assign rsp_if.ready        = rsp_ready;

    foreign_device_table_top #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    t_fd_request pending_requests[$];
    t_fd_result  expected_results[$];
    int          send_idle_pct = 36;
    int          recv_idle_pct = 68;
    int          error_count = 0;
    int          quiet_cycles = 0;

    logic        cfg_support = 1'b0;
    logic [7:0]  cfg_grace = fdt_pkg::TTL_GRACE_RESET;
    logic [31:0] tbl_ip [TABLE_DEPTH];
    logic [15:0] tbl_port [TABLE_DEPTH];
    logic [15:0] tbl_ttl [TABLE_DEPTH];
    logic [16:0] tbl_rem [TABLE_DEPTH];
    int          tbl_count = 0;

    function automatic int find_device(input logic [31:0] ip, input logic [15:0] port);
        int k;
        for (k = 0; k < tbl_count; k++) begin
            if (tbl_ip[k] == ip && tbl_port[k] == port) return k;
        end
        return tbl_count;
    endfunction

    function automatic void move_entry(input int dst, input int src);
        tbl_ip[dst]   = tbl_ip[src];
        tbl_port[dst] = tbl_port[src];
        tbl_ttl[dst]  = tbl_ttl[src];
        tbl_rem[dst]  = tbl_rem[src];
    endfunction

    function automatic t_fd_result table_apply(input t_fd_request r);
        t_fd_result res;
        int hit;
        int rd;
        int wr;
        res = '0;
        res.status = fdt_pkg::ST_OK;
        case (r.cmd)
            fdt_pkg::CMD_REGISTER: begin
                if (!cfg_support) begin
                    res.status = fdt_pkg::ST_UNSUPPORTED;
                end else if (tbl_count >= TABLE_DEPTH) begin
                    res.status = fdt_pkg::ST_FULL;
                end else begin
                    hit = find_device(r.ip, r.port);
                    if (hit < tbl_count) begin
                        tbl_ttl[hit] = r.ttl;
                        tbl_rem[hit] = 17'(r.ttl) + 17'(cfg_grace);
                    end else begin
                        tbl_ip[tbl_count]   = r.ip;
                        tbl_port[tbl_count] = r.port;
                        tbl_ttl[tbl_count]  = r.ttl;
                        tbl_rem[tbl_count]  = 17'(r.ttl);
                        tbl_count++;
                    end
                end
            end
            fdt_pkg::CMD_TICK: begin
                wr = 0;
                for (rd = 0; rd < tbl_count; rd++) begin
                    if (tbl_rem[rd] > 17'd1) begin
                        move_entry(wr, rd);
                        tbl_rem[wr] = tbl_rem[rd] - 17'd1;
                        wr++;
                    end
                end
                tbl_count = wr;
            end
            fdt_pkg::CMD_DELETE: begin
                hit = find_device(r.ip, r.port);
                if (hit >= tbl_count) begin
                    res.status = fdt_pkg::ST_NOT_FOUND;
                end else begin
                    for (rd = hit; rd + 1 < tbl_count; rd++) move_entry(rd, rd + 1);
                    tbl_count--;
                end
            end
            default: begin
                if (int'(r.idx) < tbl_count) begin
                    res.entry_valid     = 1'b1;
                    res.entry_ip        = tbl_ip[r.idx];
                    res.entry_port      = tbl_port[r.idx];
                    res.entry_ttl       = tbl_ttl[r.idx];
                    res.entry_remaining = tbl_rem[r.idx];
                end else begin
                    res.status = fdt_pkg::ST_NOT_FOUND;
                end
            end
        endcase
        res.entry_count = 5'(tbl_count);
        return res;
    endfunction

    always @(posedge i_clk) begin : drive_requests
        t_fd_request cur_req;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && req_if.ready) expected_results.push_back(table_apply(cur_req));
            if (!req_valid || req_if.ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = pending_requests.pop_front();
                    req_valid <= 1'b1;
                    req_cmd   <= cur_req.cmd;
                    req_ip    <= cur_req.ip;
                    req_port  <= cur_req.port;
                    req_ttl   <= cur_req.ttl;
                    req_idx   <= cur_req.idx;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_fd_result want;
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: status %0d", rsp_if.status);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                        error_count++;
                    end
                    if (rsp_if.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, rsp_if.entry_count);
                        error_count++;
                    end
                    if (rsp_if.entry_valid !== want.entry_valid) begin
                        $error("entry_valid: expected %0d, actual %0d",
                               want.entry_valid, rsp_if.entry_valid);
                        error_count++;
                    end
                    if (rsp_if.entry_ip !== want.entry_ip) begin
                        $error("entry_ip: expected %08h, actual %08h",
                               want.entry_ip, rsp_if.entry_ip);
                        error_count++;
                    end
                    if (rsp_if.entry_port !== want.entry_port) begin
                        $error("entry_port: expected %0d, actual %0d",
                               want.entry_port, rsp_if.entry_port);
                        error_count++;
                    end
                    if (rsp_if.entry_ttl !== want.entry_ttl) begin
                        $error("entry_ttl: expected %0d, actual %0d",
                               want.entry_ttl, rsp_if.entry_ttl);
                        error_count++;
                    end
                    if (rsp_if.entry_remaining !== want.entry_remaining) begin
                        $error("entry_remaining: expected %0d, actual %0d",
                               want.entry_remaining, rsp_if.entry_remaining);
                        error_count++;
                    end
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((req_valid && req_if.ready) || (rsp_if.valid && rsp_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("foreign_device_table_top_tb: FAIL");
            $finish;
        end
    end

    task automatic queue_item(input fdt_pkg::t_cmd cmd, input logic [31:0] ip,
                              input logic [15:0] port, input logic [15:0] ttl,
                              input logic [3:0] idx);
        t_fd_request r;
        r.cmd  = cmd;
        r.ip   = ip;
        r.port = port;
        r.ttl  = ttl;
        r.idx  = idx;
        pending_requests.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        if (idx == fdt_pkg::CFG_FD_SUPPORT) cfg_support = data[0];
        else cfg_grace = data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic build_phase(input bit fill_mode, input int n_items);
        logic [31:0] pool_ip [POOL_SIZE];
        logic [15:0] pool_port [POOL_SIZE];
        t_fd_request r;
        int pick;
        int roll;
        int k;
        for (k = 0; k < POOL_SIZE; k++) begin
            pool_ip[k]   = $urandom;
            pool_port[k] = 16'($urandom);
            if (k > 0) begin
                roll = $urandom_range(9);
                if (roll < 2) pool_ip[k] = pool_ip[k-1];
                else if (roll < 4) pool_port[k] = pool_port[k-1];
            end
        end
        for (k = 0; k < n_items; k++) begin
            pick   = $urandom_range(POOL_SIZE - 1);
            roll   = $urandom_range(99);
            r.ip   = pool_ip[pick];
            r.port = pool_port[pick];
            r.ttl  = 16'($urandom);
            r.idx  = 4'($urandom);
            if (roll < (fill_mode ? 65 : 35)) begin
                r.cmd = fdt_pkg::CMD_REGISTER;
                roll  = $urandom_range(19);
                if (roll == 0) r.ttl = 16'd0;
                else if (roll == 1) r.ttl = 16'd1;
                else if (roll == 2) r.ttl = 16'hFFFF;
                else if (!fill_mode && roll >= 5) r.ttl = 16'($urandom_range(30));
            end else if (roll < (fill_mode ? 70 : 60)) begin
                r.cmd = fdt_pkg::CMD_TICK;
            end else if (roll < (fill_mode ? 80 : 75)) begin
                r.cmd = fdt_pkg::CMD_DELETE;
                if ($urandom_range(3) == 0) r.port = 16'($urandom);
            end else begin
                r.cmd = fdt_pkg::CMD_READ;
            end
            pending_requests.push_back(r);
        end
    endtask

    initial begin : run_test
        int phase;
        wait (i_rst_n);
        @(negedge i_clk);

        // with support off: registration refused, delete and read not found, then a tick
        queue_item(fdt_pkg::CMD_REGISTER, 32'h0A00_0001, 16'hBAC0, 16'd60, 4'd0);
        queue_item(fdt_pkg::CMD_DELETE, 32'h0A00_0001, 16'hBAC0, 16'd0, 4'd0);
        queue_item(fdt_pkg::CMD_READ, 32'h0, 16'h0, 16'h0, 4'd0);
        queue_item(fdt_pkg::CMD_TICK, 32'h0, 16'h0, 16'h0, 4'd0);
        wait_idle();
        write_register(fdt_pkg::CFG_FD_SUPPORT, 8'd1);
        write_register(fdt_pkg::CFG_TTL_GRACE, 8'd255);
        @(negedge i_clk);

        queue_item(fdt_pkg::CMD_REGISTER, 32'h0000_0000, 16'h0000, 16'h0000, 4'd0);
        queue_item(fdt_pkg::CMD_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 4'd0);
        queue_item(fdt_pkg::CMD_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 4'd0);
        queue_item(fdt_pkg::CMD_REGISTER, 32'hFFFF_FFFF, 16'h0000, 16'h0001, 4'd0);
        queue_item(fdt_pkg::CMD_READ, 32'h0, 16'h0, 16'h0, 4'd0);
        queue_item(fdt_pkg::CMD_READ, 32'h0, 16'h0, 16'h0, 4'd1);
        queue_item(fdt_pkg::CMD_READ, 32'h0, 16'h0, 16'h0, 4'd2);
        queue_item(fdt_pkg::CMD_READ, 32'h0, 16'h0, 16'h0, 4'd15);
        queue_item(fdt_pkg::CMD_DELETE, 32'h0000_0000, 16'hFFFF, 16'h0, 4'd0);
        queue_item(fdt_pkg::CMD_TICK, 32'h0, 16'h0, 16'h0, 4'd0);
        queue_item(fdt_pkg::CMD_READ, 32'h0, 16'h0, 16'h0, 4'd0);
        queue_item(fdt_pkg::CMD_DELETE, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 4'd0);
        queue_item(fdt_pkg::CMD_READ, 32'h0, 16'h0, 16'h0, 4'd0);
        queue_item(fdt_pkg::CMD_DELETE, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 4'd0);
        wait_idle();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == PHASE_COUNT / 3) begin
                send_idle_pct = 68;
                recv_idle_pct = 36;
            end else if (phase == 2 * PHASE_COUNT / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_register(fdt_pkg::CFG_FD_SUPPORT, (phase == 2 || phase == 7) ? 8'd0 : 8'd1);
            write_register(fdt_pkg::CFG_TTL_GRACE, (phase == 0) ? 8'd0 :
                                                   (phase == 1) ? 8'd255 :
                                                   8'($urandom_range(255)));
            @(negedge i_clk);
            build_phase(phase % 3 == 0, PHASE_ITEMS);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("foreign_device_table_top_tb: PASS");
        end else begin
            $display("foreign_device_table_top_tb: FAIL");
        end
        $finish;
    end

endmodule
